// File: rtl/pdsd_pkg.sv
package pdsd_pkg;

	// Frame layout
	localparam int FRAME_BITS = 36;
	localparam int BIT_CNT_W  = 6;
	localparam int TS_W       = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;

	// Accepted temperature range, tenths of a degree
	localparam int TEMP_MIN = -600;
	localparam int TEMP_MAX = 700;

	// Accepted sensor types
	localparam logic [3:0] TYPE_A = 4'd5;
	localparam logic [3:0] TYPE_B = 4'd9;

	// Result status codes
	typedef enum logic [3:0] {
		ST_WAIT     = 4'd0,
		ST_START    = 4'd1,
		ST_FALL_OK  = 4'd2,
		ST_NEXT_BIT = 4'd3,
		ST_PACKET   = 4'd4,
		ST_BAD_HIGH = 4'd5,
		ST_BAD_GAP  = 4'd6,
		ST_BAD_TEMP = 4'd7,
		ST_BAD_TYPE = 4'd8
	} status_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_GAP_MIN   = 3'd0,
		REG_HIGH_PULSE_MIN = 3'd1,
		REG_HIGH_PULSE_MAX = 3'd2,
		REG_ZERO_GAP_MIN   = 3'd3,
		REG_ZERO_GAP_MAX   = 3'd4,
		REG_ONE_GAP_MIN    = 3'd5,
		REG_ONE_GAP_MAX    = 3'd6,
		REG_UNUSED         = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_SYNC_GAP_MIN   = 16'd8900;
	localparam logic [CFG_W-1:0] RST_HIGH_PULSE_MIN = 16'd400;
	localparam logic [CFG_W-1:0] RST_HIGH_PULSE_MAX = 16'd600;
	localparam logic [CFG_W-1:0] RST_ZERO_GAP_MIN   = 16'd1900;
	localparam logic [CFG_W-1:0] RST_ZERO_GAP_MAX   = 16'd2100;
	localparam logic [CFG_W-1:0] RST_ONE_GAP_MIN    = 16'd3900;
	localparam logic [CFG_W-1:0] RST_ONE_GAP_MAX    = 16'd4100;

	// Timing windows handed from the register file to the decoder
	typedef struct packed {
		logic [CFG_W-1:0] sync_gap_min;
		logic [CFG_W-1:0] high_pulse_min;
		logic [CFG_W-1:0] high_pulse_max;
		logic [CFG_W-1:0] zero_gap_min;
		logic [CFG_W-1:0] zero_gap_max;
		logic [CFG_W-1:0] one_gap_min;
		logic [CFG_W-1:0] one_gap_max;
	} cfg_t;

endpackage

// File: rtl/pdsd_if.sv
// Edge event channel
interface pdsd_evt_if;
	logic                           valid;
	logic                           ready;
	logic                           rising;
	logic [pdsd_pkg::TS_W-1:0]      timestamp;

	modport source (output valid, rising, timestamp, input ready);
	modport sink   (input valid, rising, timestamp, output ready);
endinterface

// Decode result channel
interface pdsd_res_if;
	logic              valid;
	logic              ready;
	logic [3:0]        status;
	logic              packet_valid;
	logic [7:0]        humidity;
	logic signed [10:0] temperature;
	logic [1:0]        channel;
	logic              battery_low;
	logic [7:0]        sensor_id;
	logic [3:0]        sensor_type;

	modport source (output valid, status, packet_valid, humidity, temperature, channel,
		battery_low, sensor_id, sensor_type, input ready);
	modport sink   (input valid, status, packet_valid, humidity, temperature, channel,
		battery_low, sensor_id, sensor_type, output ready);
endinterface

// Configuration write channel
interface pdsd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pdsd_pkg::CFG_IDX_W-1:0]    index;
	logic [pdsd_pkg::CFG_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pdsd_cfg_regs.sv
module pdsd_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	pdsd_cfg_if.sink           cfg,
	output pdsd_pkg::cfg_t     regs
);

	pdsd_pkg::cfg_t regs_q;

	// Writes are always taken
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register file; writes to the unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sync_gap_min   <= pdsd_pkg::RST_SYNC_GAP_MIN;
			regs_q.high_pulse_min <= pdsd_pkg::RST_HIGH_PULSE_MIN;
			regs_q.high_pulse_max <= pdsd_pkg::RST_HIGH_PULSE_MAX;
			regs_q.zero_gap_min   <= pdsd_pkg::RST_ZERO_GAP_MIN;
			regs_q.zero_gap_max   <= pdsd_pkg::RST_ZERO_GAP_MAX;
			regs_q.one_gap_min    <= pdsd_pkg::RST_ONE_GAP_MIN;
			regs_q.one_gap_max    <= pdsd_pkg::RST_ONE_GAP_MAX;
		end else if (cfg.valid) begin
			unique case (pdsd_pkg::reg_idx_t'(cfg.index))
				pdsd_pkg::REG_SYNC_GAP_MIN:   regs_q.sync_gap_min   <= cfg.data;
				pdsd_pkg::REG_HIGH_PULSE_MIN: regs_q.high_pulse_min <= cfg.data;
				pdsd_pkg::REG_HIGH_PULSE_MAX: regs_q.high_pulse_max <= cfg.data;
				pdsd_pkg::REG_ZERO_GAP_MIN:   regs_q.zero_gap_min   <= cfg.data;
				pdsd_pkg::REG_ZERO_GAP_MAX:   regs_q.zero_gap_max   <= cfg.data;
				pdsd_pkg::REG_ONE_GAP_MIN:    regs_q.one_gap_min    <= cfg.data;
				pdsd_pkg::REG_ONE_GAP_MAX:    regs_q.one_gap_max    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/pulse_distance_sensor_frame_decoder.sv
// Pulse-distance sensor frame decoder. Each edge event (direction and a free-running
// 32-bit timestamp) yields exactly one result transaction with a status code; a
// complete 36-bit frame whose temperature lies in -60.0..70.0 degrees and whose type
// is 5 or 9 comes out with status packet, packet_valid high and the unpacked fields,
// and every other result carries zeros in those fields. One event is taken per cycle
// while results are taken: an event is captured in the input register, the gap windows
// and frame checks are evaluated combinationally from it, and the result register then
// presents the status and fields. The user must write the timing windows over the cfg
// channel only while no event is in flight; the block does not enforce this. A decode
// error or a finished frame returns the decoder to idle.
module pulse_distance_sensor_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	pdsd_evt_if.sink   evt,
	pdsd_res_if.source res,
	pdsd_cfg_if.sink   cfg
);

	pdsd_pkg::cfg_t regs;

	pdsd_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Input register
	logic                            v_s1;
	logic                            rising_s1;
	logic [pdsd_pkg::TS_W-1:0]       ts_s1;

	// Decoder state
	logic [pdsd_pkg::TS_W-1:0]       last_q;
	logic                            rx_q;
	logic [pdsd_pkg::BIT_CNT_W-1:0]  cnt_q;
	logic [pdsd_pkg::FRAME_BITS-1:0] shift_q;

	// Result register
	logic                            v_s2;
	pdsd_pkg::status_t               status_s2;
	logic                            pkt_s2;
	logic [7:0]                      hum_s2;
	logic signed [10:0]              temp_s2;
	logic [1:0]                      chan_s2;
	logic                            batt_s2;
	logic [7:0]                      id_s2;
	logic [3:0]                      type_s2;

	logic adv;

	assign adv       = v_s1 && (!v_s2 || res.ready);
	assign evt.ready = !v_s1 || adv;

	// Decode of the event held in the input register
	logic [pdsd_pkg::TS_W-1:0]       gap;
	logic                            in_high, in_zero, in_one, in_sync;
	logic [pdsd_pkg::FRAME_BITS-1:0] shift_nxt;
	logic [pdsd_pkg::BIT_CNT_W-1:0]  cnt_inc;
	logic signed [11:0]              temp12;
	logic                            temp_ok, type_ok;
	logic                            rx_nxt;
	logic [pdsd_pkg::BIT_CNT_W-1:0]  cnt_nxt;
	logic [pdsd_pkg::FRAME_BITS-1:0] shift_upd;
	pdsd_pkg::status_t               status_nxt;

	always_comb begin
		gap     = ts_s1 - last_q;
		in_sync = gap >= {16'd0, regs.sync_gap_min};
		in_high = (gap >= {16'd0, regs.high_pulse_min}) && (gap <= {16'd0, regs.high_pulse_max});
		in_zero = (gap >= {16'd0, regs.zero_gap_min}) && (gap <= {16'd0, regs.zero_gap_max});
		in_one  = (gap >= {16'd0, regs.one_gap_min}) && (gap <= {16'd0, regs.one_gap_max});

		shift_nxt = {shift_q[pdsd_pkg::FRAME_BITS-2:0], !in_zero};
		cnt_inc   = cnt_q + pdsd_pkg::BIT_CNT_W'(1);
		temp12    = $signed(shift_nxt[19:8]);
		temp_ok   = (temp12 >= 12'(pdsd_pkg::TEMP_MIN)) && (temp12 <= 12'(pdsd_pkg::TEMP_MAX));
		type_ok   = (shift_nxt[35:32] == pdsd_pkg::TYPE_A) ||
		            (shift_nxt[35:32] == pdsd_pkg::TYPE_B);

		rx_nxt     = rx_q;
		cnt_nxt    = cnt_q;
		shift_upd  = shift_q;
		status_nxt = pdsd_pkg::ST_WAIT;

		if (!rx_q) begin
			// idle: wait for a long gap before a rising edge
			if (rising_s1 && in_sync) begin
				rx_nxt     = 1'b1;
				cnt_nxt    = '0;
				shift_upd  = '0;
				status_nxt = pdsd_pkg::ST_START;
			end
		end else if (!rising_s1) begin
			// falling edge: check high pulse width
			if (in_high) begin
				status_nxt = pdsd_pkg::ST_FALL_OK;
			end else begin
				rx_nxt     = 1'b0;
				status_nxt = pdsd_pkg::ST_BAD_HIGH;
			end
		end else if (!in_zero && !in_one) begin
			rx_nxt     = 1'b0;
			status_nxt = pdsd_pkg::ST_BAD_GAP;
		end else begin
			// rising edge: shift in a data bit, zero window wins on overlap
			shift_upd = shift_nxt;
			cnt_nxt   = cnt_inc;
			if (cnt_inc < pdsd_pkg::BIT_CNT_W'(pdsd_pkg::FRAME_BITS)) begin
				status_nxt = pdsd_pkg::ST_NEXT_BIT;
			end else begin
				rx_nxt = 1'b0;
				if (!temp_ok) begin
					status_nxt = pdsd_pkg::ST_BAD_TEMP;
				end else if (!type_ok) begin
					status_nxt = pdsd_pkg::ST_BAD_TYPE;
				end else begin
					status_nxt = pdsd_pkg::ST_PACKET;
				end
			end
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.ready) begin
			v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			rising_s1 <= evt.rising;
			ts_s1     <= evt.timestamp;
		end
	end

	// Decoder state, updated as each event moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			rx_q    <= 1'b0;
			cnt_q   <= '0;
			shift_q <= '0;
		end else if (adv) begin
			last_q  <= ts_s1;
			rx_q    <= rx_nxt;
			cnt_q   <= cnt_nxt;
			shift_q <= shift_upd;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (res.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_nxt;
			if (status_nxt == pdsd_pkg::ST_PACKET) begin
				pkt_s2  <= 1'b1;
				hum_s2  <= shift_nxt[7:0];
				temp_s2 <= temp12[10:0];
				chan_s2 <= shift_nxt[21:20];
				batt_s2 <= shift_nxt[23];
				id_s2   <= shift_nxt[31:24];
				type_s2 <= shift_nxt[35:32];
			end else begin
				pkt_s2  <= 1'b0;
				hum_s2  <= '0;
				temp_s2 <= '0;
				chan_s2 <= '0;
				batt_s2 <= 1'b0;
				id_s2   <= '0;
				type_s2 <= '0;
			end
		end
	end

	assign res.valid        = v_s2;
	assign res.status       = status_s2;
	assign res.packet_valid = pkt_s2;
	assign res.humidity     = hum_s2;
	assign res.temperature  = temp_s2;
	assign res.channel      = chan_s2;
	assign res.battery_low  = batt_s2;
	assign res.sensor_id    = id_s2;
	assign res.sensor_type  = type_s2;

endmodule

// File: rtl/pdsd_checker.sv
module pdsd_sva (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [3:0]        res_status,
	input logic              res_packet_valid,
	input logic [7:0]        res_humidity,
	input logic signed [10:0] res_temperature,
	input logic [7:0]        res_sensor_id,
	input logic [3:0]        res_sensor_type
);

	// packet_valid flags exactly the packet status
	a_pkt_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_packet_valid == (res_status == pdsd_pkg::ST_PACKET)))
		else $error("packet_valid does not match status");

	// non-packet results carry zero humidity, temperature, sensor id and sensor type
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_packet_valid) |->
		(res_humidity == 8'd0 && res_temperature == 11'sd0 &&
		 res_sensor_id == 8'd0 && res_sensor_type == 4'd0))
		else $error("non-packet result with nonzero fields");

	// a packet passed the type and temperature checks
	a_pkt_checked: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_packet_valid) |->
		((res_sensor_type == pdsd_pkg::TYPE_A || res_sensor_type == pdsd_pkg::TYPE_B) &&
		 res_temperature >= -11'sd600 && res_temperature <= 11'sd700))
		else $error("packet with out-of-range type or temperature");

	// a stalled result stays valid and keeps its status
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_status)))
		else $error("stalled result changed");

endmodule

bind pulse_distance_sensor_frame_decoder pdsd_sva u_pdsd_sva (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_status       (res.status),
	.res_packet_valid (res.packet_valid),
	.res_humidity     (res.humidity),
	.res_temperature  (res.temperature),
	.res_sensor_id    (res.sensor_id),
	.res_sensor_type  (res.sensor_type)
);
